// ----- hdl/lldp_pkg.sv -----
package lldp_pkg;

	localparam logic [15:0] LLDP_ETHERTYPE = 16'h88cc;
	localparam logic [4:0]  HDR_BYTES      = 5'd14;
	localparam int          CAP_BRIDGE_BIT = 2;
	localparam int          CAP_ROUTER_BIT = 4;

	localparam logic [6:0] TLV_END     = 7'd0;
	localparam logic [6:0] TLV_CHASSIS = 7'd1;
	localparam logic [6:0] TLV_PORT    = 7'd2;
	localparam logic [6:0] TLV_TTL     = 7'd3;
	localparam logic [6:0] TLV_CAPS    = 7'd7;
	localparam logic [6:0] TLV_MGMT    = 7'd8;

	localparam logic [7:0] CHASSIS_SUB_MAC  = 8'd4;
	localparam logic [7:0] CHASSIS_SUB_NET  = 8'd5;
	localparam logic [7:0] PORT_SUB_MAC     = 8'd3;
	localparam logic [7:0] MGMT_ADDR_LEN    = 8'd5;
	localparam logic [7:0] ADDR_FAMILY_IPV4 = 8'd1;

	localparam logic [1:0] CHASSIS_KIND_NONE  = 2'd0;
	localparam logic [1:0] CHASSIS_KIND_MAC   = 2'd1;
	localparam logic [1:0] CHASSIS_KIND_IPV4  = 2'd2;
	localparam logic [1:0] CHASSIS_KIND_OTHER = 2'd3;

	localparam logic [1:0] PORT_KIND_NONE  = 2'd0;
	localparam logic [1:0] PORT_KIND_MAC   = 2'd1;
	localparam logic [1:0] PORT_KIND_OTHER = 2'd2;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_in_t;

	typedef struct packed {
		logic [15:0] time_to_live;
		logic [15:0] system_caps;
		logic [15:0] enabled_caps;
		logic        is_bridge;
		logic        is_router;
		logic [1:0]  chassis_kind;
		logic [47:0] chassis_address;
		logic [1:0]  port_kind;
		logic [47:0] port_mac;
		logic [31:0] mgmt_ipv4;
		logic        mgmt_valid;
	} summary_t;

endpackage

// ----- hdl/lldp_if.sv -----
interface lldp_in_if import lldp_pkg::*; ();
	logic      valid;
	logic      ready;
	frame_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lldp_out_if import lldp_pkg::*; ();
	logic     valid;
	logic     ready;
	summary_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/lldp_walker.sv -----
module lldp_walker import lldp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  frame_in_t item,
	output logic      res_valid,
	output summary_t  res
);

	localparam logic [4:0] HDR_SAT = 5'd16;

	typedef enum logic [1:0] {PH_HDR0, PH_HDR1, PH_VALUE, PH_STOP} phase_t;

	typedef struct packed {
		logic [15:0] ttl;
		logic [15:0] sys_caps;
		logic [15:0] en_caps;
		logic [1:0]  ch_kind;
		logic [47:0] ch_addr;
		logic [1:0]  port_kind;
		logic [47:0] port_mac;
		logic [31:0] mgmt_ip;
		logic        mgmt_valid;
	} held_t;

	function automatic held_t commit_tlv(
		input logic [6:0]  kind,
		input logic [8:0]  len,
		input logic [7:0]  first,
		input logic [7:0]  second,
		input logic [47:0] gather,
		input held_t       held
	);
		held_t h;
		h = held;
		unique case (kind)
			TLV_CHASSIS: begin
				if (len >= 9'd1) begin
					if (first == CHASSIS_SUB_MAC && len == 9'd7) begin
						h.ch_kind = CHASSIS_KIND_MAC;
						h.ch_addr = gather;
					end else if (first == CHASSIS_SUB_NET && len >= 9'd6
							&& second == ADDR_FAMILY_IPV4) begin
						h.ch_kind = CHASSIS_KIND_IPV4;
						h.ch_addr = {16'h0000, gather[39:8]};
					end else begin
						h.ch_kind = CHASSIS_KIND_OTHER;
						h.ch_addr = '0;
					end
				end
			end
			TLV_PORT: begin
				if (len >= 9'd1) begin
					if (first == PORT_SUB_MAC && len == 9'd7) begin
						h.port_kind = PORT_KIND_MAC;
						h.port_mac  = gather;
					end else begin
						h.port_kind = PORT_KIND_OTHER;
						h.port_mac  = '0;
					end
				end
			end
			TLV_TTL: begin
				if (len >= 9'd2) begin
					h.ttl = {first, second};
				end
			end
			TLV_CAPS: begin
				if (len >= 9'd4) begin
					h.sys_caps = {first, second};
					h.en_caps  = gather[39:24];
				end
			end
			TLV_MGMT: begin
				if (len >= 9'd6 && first == MGMT_ADDR_LEN && second == ADDR_FAMILY_IPV4) begin
					h.mgmt_ip    = gather[39:8];
					h.mgmt_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return h;
	endfunction

	logic [4:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  type_hi_q, type_hi_d;
	logic        type_ok_q, type_ok_d;
	phase_t      phase_q, phase_d;
	logic [6:0]  kind_q, kind_d;
	logic [8:0]  len_q, len_d;
	logic [8:0]  vidx_q, vidx_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  second_q, second_d;
	logic [47:0] gather_q, gather_d;
	held_t       held_q, held_d, held_walk;
	logic [7:0]  b;
	logic        qualifies;

	assign b = item.frame_byte;

	always_comb begin
		hdr_cnt_d = hdr_cnt_q;
		type_hi_d = type_hi_q;
		type_ok_d = type_ok_q;
		phase_d   = phase_q;
		kind_d    = kind_q;
		len_d     = len_q;
		vidx_d    = vidx_q;
		first_d   = first_q;
		second_d  = second_q;
		gather_d  = gather_q;
		held_walk = held_q;

		if (hdr_cnt_q < HDR_BYTES) begin
			if (hdr_cnt_q == 5'd12) begin
				type_hi_d = b;
			end
			if (hdr_cnt_q == 5'd13) begin
				type_ok_d = ({type_hi_q, b} == LLDP_ETHERTYPE);
			end
		end else begin
			unique case (phase_q)
				PH_HDR0: begin
					kind_d  = b[7:1];
					len_d   = {b[0], 8'h00};
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					len_d    = {len_q[8], b};
					vidx_d   = '0;
					first_d  = '0;
					second_d = '0;
					gather_d = '0;
					if (kind_q == TLV_END) begin
						phase_d = PH_STOP;
					end else if (len_d == 9'd0) begin
						// An empty value leaves every summary field as it was.
						phase_d = PH_HDR0;
					end else begin
						phase_d = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (vidx_q == 9'd0) begin
						first_d = b;
					end
					if (vidx_q == 9'd1) begin
						second_d = b;
					end
					for (int k = 1; k <= 6; k++) begin
						if (vidx_q == 9'(k)) begin
							gather_d[(6 - k) * 8 +: 8] = b;
						end
					end
					vidx_d = vidx_q + 9'd1;
					if (vidx_d >= len_q) begin
						held_walk = commit_tlv(kind_q, len_q, first_d, second_d,
							gather_d, held_q);
						phase_d = PH_HDR0;
					end
				end
				PH_STOP: begin
				end
				default: begin
				end
			endcase
		end

		if (hdr_cnt_q != HDR_SAT) begin
			hdr_cnt_d = hdr_cnt_q + 5'd1;
		end

		held_d = held_walk;
		if (item.frame_end) begin
			hdr_cnt_d = '0;
			type_hi_d = '0;
			type_ok_d = 1'b0;
			phase_d   = PH_HDR0;
			kind_d    = '0;
			len_d     = '0;
			vidx_d    = '0;
			first_d   = '0;
			second_d  = '0;
			gather_d  = '0;
			held_d    = '0;
		end
	end

	assign qualifies = (hdr_cnt_q >= 5'd15) && type_ok_q;
	assign res_valid = fire && item.frame_end && qualifies;

	always_comb begin
		res.time_to_live    = held_walk.ttl;
		res.system_caps     = held_walk.sys_caps;
		res.enabled_caps    = held_walk.en_caps;
		res.is_bridge       = held_walk.en_caps[CAP_BRIDGE_BIT];
		res.is_router       = held_walk.en_caps[CAP_ROUTER_BIT];
		res.chassis_kind    = held_walk.ch_kind;
		res.chassis_address = held_walk.ch_addr;
		res.port_kind       = held_walk.port_kind;
		res.port_mac        = held_walk.port_mac;
		res.mgmt_ipv4       = held_walk.mgmt_ip;
		res.mgmt_valid      = held_walk.mgmt_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			type_hi_q <= '0;
			type_ok_q <= 1'b0;
			phase_q   <= PH_HDR0;
			kind_q    <= '0;
			len_q     <= '0;
			vidx_q    <= '0;
			first_q   <= '0;
			second_q  <= '0;
			gather_q  <= '0;
			held_q    <= '0;
		end else if (fire) begin
			hdr_cnt_q <= hdr_cnt_d;
			type_hi_q <= type_hi_d;
			type_ok_q <= type_ok_d;
			phase_q   <= phase_d;
			kind_q    <= kind_d;
			len_q     <= len_d;
			vidx_q    <= vidx_d;
			first_q   <= first_d;
			second_q  <= second_d;
			gather_q  <= gather_d;
			held_q    <= held_d;
		end
	end

endmodule

// ----- hdl/lldp_out_reg.sv -----
module lldp_out_reg import lldp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  summary_t res,
	output logic     can_take,
	lldp_out_if.source out
);

	logic     valid_q;
	summary_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign can_take  = !valid_q || out.ready;
	assign out.valid = valid_q;
	assign out.data  = data_q;

endmodule

// ----- hdl/lldp_tlv_frame_parser.sv -----
// Channel       Dir  Payload                                   Request
// frame_in      in   frame_byte, frame_end                     one frame byte
// summary_out   out  caps, TTL, chassis, port, mgmt address    one summary per LLDP frame
//
// One frame byte is taken every cycle; the summary shows up the cycle after the final byte.
// The per-byte walker updates its state in the accepting cycle; a result register holds
// the summary. frame_in stalls only while that register is full and not being taken.
// Reset clears all parser state and the result register's valid flag; no clearing pass is needed.
module lldp_tlv_frame_parser import lldp_pkg::*; (
	input logic clk,
	input logic arst_n,
	lldp_in_if.sink frame_in,
	lldp_out_if.source summary_out
);

	logic     fire;
	logic     can_take;
	logic     res_valid;
	summary_t res;

	assign frame_in.ready = can_take;
	assign fire           = frame_in.valid && can_take;

	lldp_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (frame_in.data),
		.res_valid (res_valid),
		.res       (res)
	);

	lldp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.can_take (can_take),
		.out      (summary_out)
	);

	a_result_from_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(summary_out.valid) |->
			$past(frame_in.valid && frame_in.ready && frame_in.data.frame_end))
		else $error("summary appeared without a final frame byte");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_in.ready |-> summary_out.valid)
		else $error("input stalled with an empty result register");

	a_flags_match_caps: assert property (@(posedge clk) disable iff (!arst_n)
		summary_out.valid |->
			summary_out.data.is_bridge == summary_out.data.enabled_caps[CAP_BRIDGE_BIT]
			&& summary_out.data.is_router == summary_out.data.enabled_caps[CAP_ROUTER_BIT])
		else $error("bridge or router flag disagrees with enabled capabilities");

	a_port_mac_kind: assert property (@(posedge clk) disable iff (!arst_n)
		summary_out.valid && summary_out.data.port_kind != PORT_KIND_MAC |->
			summary_out.data.port_mac == 48'h0)
		else $error("port MAC set for a non-MAC port ID");

endmodule

// ----- test/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lldp_pkg::*;

	localparam logic [1:0] WALK_HEAD  = 2'd0;
	localparam logic [1:0] WALK_LEN   = 2'd1;
	localparam logic [1:0] WALK_VALUE = 2'd2;
	localparam logic [1:0] WALK_DONE  = 2'd3;

	localparam logic [6:0] TLV_PORT_DESC = 7'd4;
	localparam logic [6:0] TLV_SYS_DESC  = 7'd6;
	localparam logic [6:0] TLV_VENDOR    = 7'd127;

	localparam logic [7:0] CHASSIS_SUB_LOCAL = 8'd7;
	localparam logic [7:0] PORT_SUB_IFNAME   = 8'd5;
	localparam logic [7:0] MGMT_LEN_IPV6     = 8'd17;
	localparam logic [7:0] ADDR_FAMILY_IPV6  = 8'd2;

	localparam int TARGET_BYTES   = 1550;
	localparam int TARGET_FRAMES  = 20;
	localparam int STALL_LIMIT    = 2000;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		frame_in_t item;
		bit        hold;
	} frame_req_t;

	logic clk;
	logic arst_n;

	lldp_in_if  frame_in ();
	lldp_out_if summary_out ();

	lldp_tlv_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_in(frame_in),
		.summary_out(summary_out)
	);

	frame_req_t byte_stream[$];
	summary_t   expected_summaries[$];
	logic [7:0] frame_buf[$];
	logic [7:0] tlv_val[$];

	int total_items;
	int bytes_accepted;
	int frames_sent;
	int lldp_frames_planned;
	int summaries_checked;
	int mismatches;
	int stall_cycles;

	// Predicted parser state.
	logic [4:0]  hdr_cnt;
	logic [7:0]  etype_hi;
	logic        etype_ok;
	logic [1:0]  walk;
	logic [6:0]  cur_kind;
	logic [8:0]  cur_len;
	logic [8:0]  val_idx;
	logic [7:0]  val0;
	logic [7:0]  val1;
	logic [47:0] gather;
	summary_t    held;

	function automatic void clear_frame_state();
		hdr_cnt  = '0;
		etype_hi = '0;
		etype_ok = 1'b0;
		walk     = WALK_HEAD;
		cur_kind = '0;
		cur_len  = '0;
		val_idx  = '0;
		val0     = '0;
		val1     = '0;
		gather   = '0;
		held     = '0;
	endfunction

	function automatic void apply_tlv();
		case (cur_kind)
			TLV_CHASSIS: begin
				if (cur_len >= 1) begin
					if (val0 == CHASSIS_SUB_MAC && cur_len == 7) begin
						held.chassis_kind    = CHASSIS_KIND_MAC;
						held.chassis_address = gather;
					end else if (val0 == CHASSIS_SUB_NET && cur_len >= 6 &&
							val1 == ADDR_FAMILY_IPV4) begin
						held.chassis_kind    = CHASSIS_KIND_IPV4;
						held.chassis_address = {16'h0000, gather[39:8]};
					end else begin
						held.chassis_kind    = CHASSIS_KIND_OTHER;
						held.chassis_address = '0;
					end
				end
			end
			TLV_PORT: begin
				if (cur_len >= 1) begin
					if (val0 == PORT_SUB_MAC && cur_len == 7) begin
						held.port_kind = PORT_KIND_MAC;
						held.port_mac  = gather;
					end else begin
						held.port_kind = PORT_KIND_OTHER;
						held.port_mac  = '0;
					end
				end
			end
			TLV_TTL: begin
				if (cur_len >= 2)
					held.time_to_live = {val0, val1};
			end
			TLV_CAPS: begin
				if (cur_len >= 4) begin
					held.system_caps  = {val0, val1};
					held.enabled_caps = gather[39:24];
				end
			end
			TLV_MGMT: begin
				if (cur_len >= 6 && val0 == MGMT_ADDR_LEN && val1 == ADDR_FAMILY_IPV4) begin
					held.mgmt_ipv4  = gather[39:8];
					held.mgmt_valid = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void parse_byte(input frame_in_t it);
		logic [4:0] idx;
		logic [7:0] b;
		summary_t   s;
		idx = hdr_cnt;
		b   = it.frame_byte;
		if (idx < HDR_BYTES) begin
			if (idx == 5'd12)
				etype_hi = b;
			if (idx == 5'd13)
				etype_ok = ({etype_hi, b} == LLDP_ETHERTYPE);
		end else begin
			case (walk)
				WALK_HEAD: begin
					cur_kind = b[7:1];
					cur_len  = {b[0], 8'h00};
					walk     = WALK_LEN;
				end
				WALK_LEN: begin
					cur_len = {cur_len[8], b};
					val_idx = '0;
					val0    = '0;
					val1    = '0;
					gather  = '0;
					if (cur_kind == TLV_END) begin
						walk = WALK_DONE;
					end else if (cur_len == 0) begin
						apply_tlv();
						walk = WALK_HEAD;
					end else begin
						walk = WALK_VALUE;
					end
				end
				WALK_VALUE: begin
					if (val_idx == 0)
						val0 = b;
					if (val_idx == 1)
						val1 = b;
					if (val_idx >= 1 && val_idx <= 6)
						gather[(6 - val_idx) * 8 +: 8] = b;
					val_idx = val_idx + 9'd1;
					if (val_idx >= cur_len) begin
						apply_tlv();
						walk = WALK_HEAD;
					end
				end
				default: ;
			endcase
		end
		if (hdr_cnt < 5'd16)
			hdr_cnt = hdr_cnt + 5'd1;
		if (it.frame_end) begin
			if (idx >= 5'd15 && etype_ok) begin
				s = held;
				s.is_bridge = held.enabled_caps[CAP_BRIDGE_BIT];
				s.is_router = held.enabled_caps[CAP_ROUTER_BIT];
				expected_summaries.push_back(s);
			end
			clear_frame_state();
		end
	endfunction

	function automatic void compare_field(input string name, input logic [47:0] want,
			input logic [47:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%t summary %0d, %s: expected %h, got %h", $realtime,
					summaries_checked, name, want, got);
		end
	endfunction

	function automatic void check_summary(input summary_t got);
		summary_t want;
		if (expected_summaries.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%t summary with none expected: %h", $realtime, got);
		end else begin
			want = expected_summaries.pop_front();
			summaries_checked++;
			compare_field("time_to_live", 48'(want.time_to_live), 48'(got.time_to_live));
			compare_field("system_caps", 48'(want.system_caps), 48'(got.system_caps));
			compare_field("enabled_caps", 48'(want.enabled_caps), 48'(got.enabled_caps));
			compare_field("is_bridge", 48'(want.is_bridge), 48'(got.is_bridge));
			compare_field("is_router", 48'(want.is_router), 48'(got.is_router));
			compare_field("chassis_kind", 48'(want.chassis_kind), 48'(got.chassis_kind));
			compare_field("chassis_address", want.chassis_address, got.chassis_address);
			compare_field("port_kind", 48'(want.port_kind), 48'(got.port_kind));
			compare_field("port_mac", want.port_mac, got.port_mac);
			compare_field("mgmt_ipv4", 48'(want.mgmt_ipv4), 48'(got.mgmt_ipv4));
			compare_field("mgmt_valid", 48'(want.mgmt_valid), 48'(got.mgmt_valid));
		end
	endfunction

	function automatic int traffic_phase();
		if (total_items == 0)
			return 2;
		return (bytes_accepted * 3) / total_items;
	endfunction

	function automatic int sender_idle_pct();
		case (traffic_phase())
			0: return 28;
			1: return 45;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (traffic_phase())
			0: return 45;
			1: return 28;
			default: return 0;
		endcase
	endfunction

	task automatic add_random(input int n);
		repeat (n) tlv_val.push_back(8'($urandom_range(255)));
	endtask

	task automatic add_bytes(input logic [47:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			tlv_val.push_back(v[i * 8 +: 8]);
	endtask

	task automatic put_tlv(input logic [6:0] kind);
		logic [8:0] len;
		len = 9'(tlv_val.size());
		frame_buf.push_back({kind, len[8]});
		frame_buf.push_back(len[7:0]);
		foreach (tlv_val[i])
			frame_buf.push_back(tlv_val[i]);
		tlv_val.delete();
	endtask

	task automatic start_frame(input logic [15:0] etype);
		frame_buf.delete();
		repeat (12) frame_buf.push_back(8'($urandom_range(255)));
		frame_buf.push_back(etype[15:8]);
		frame_buf.push_back(etype[7:0]);
	endtask

	task automatic send_frame(input bit hold);
		frame_req_t r;
		if (frame_buf.size() >= 16 && {frame_buf[12], frame_buf[13]} == LLDP_ETHERTYPE)
			lldp_frames_planned++;
		foreach (frame_buf[i]) begin
			r.item.frame_byte = frame_buf[i];
			r.item.frame_end  = (i == frame_buf.size() - 1);
			r.hold            = hold && (i == 0);
			byte_stream.push_back(r);
		end
		frames_sent++;
	endtask

	task automatic put_random_tlv();
		logic [6:0] kind;
		int pick;
		int cut;
		pick = $urandom_range(99);
		if (pick < 15) begin
			kind = TLV_CHASSIS;
			case ($urandom_range(2))
				0: begin
					tlv_val.push_back(CHASSIS_SUB_MAC);
					add_random(($urandom_range(4) == 0) ? $urandom_range(4, 7) : 6);
				end
				1: begin
					tlv_val.push_back(CHASSIS_SUB_NET);
					tlv_val.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
						ADDR_FAMILY_IPV4);
					add_random($urandom_range(4, 6));
				end
				default: begin
					tlv_val.push_back(8'($urandom_range(255)));
					add_random($urandom_range(0, 9));
				end
			endcase
		end else if (pick < 30) begin
			kind = TLV_PORT;
			if ($urandom_range(1)) begin
				tlv_val.push_back(PORT_SUB_MAC);
				add_random(($urandom_range(4) == 0) ? $urandom_range(4, 7) : 6);
			end else begin
				tlv_val.push_back(8'($urandom_range(255)));
				add_random($urandom_range(0, 9));
			end
		end else if (pick < 45) begin
			kind = TLV_TTL;
			add_random(($urandom_range(5) == 0) ? $urandom_range(0, 4) : 2);
		end else if (pick < 60) begin
			kind = TLV_CAPS;
			add_random(($urandom_range(5) == 0) ? $urandom_range(0, 6) : 4);
		end else if (pick < 75) begin
			kind = TLV_MGMT;
			tlv_val.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) :
				MGMT_ADDR_LEN);
			tlv_val.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) :
				ADDR_FAMILY_IPV4);
			add_random(4 + $urandom_range(0, 8));
		end else if (pick < 82) begin
			kind = 7'($urandom_range(TLV_CHASSIS, TLV_MGMT));
		end else begin
			kind = $urandom_range(1) ? 7'($urandom_range(TLV_PORT_DESC, TLV_SYS_DESC)) :
				7'($urandom_range(TLV_MGMT + 1, TLV_VENDOR));
			add_random(($urandom_range(40) == 0) ? $urandom_range(256, 511) :
				$urandom_range(0, 12));
		end
		if ($urandom_range(9) == 0) begin
			cut = $urandom_range(0, tlv_val.size());
			while (tlv_val.size() > cut)
				void'(tlv_val.pop_back());
		end
		put_tlv(kind);
	endtask

	task automatic random_frame();
		int pick;
		int cut;
		pick = $urandom_range(99);
		if (pick < 8) begin
			start_frame($urandom_range(1) ? LLDP_ETHERTYPE : 16'($urandom_range(16'hffff)));
			repeat ($urandom_range(0, 10)) frame_buf.push_back(8'($urandom_range(255)));
			cut = $urandom_range(1, frame_buf.size());
			while (frame_buf.size() > cut)
				void'(frame_buf.pop_back());
		end else begin
			start_frame((pick < 14) ? LLDP_ETHERTYPE ^ (16'h0001 << $urandom_range(15)) :
				LLDP_ETHERTYPE);
			repeat ($urandom_range(1, 5)) put_random_tlv();
			if ($urandom_range(9) != 0)
				put_tlv(TLV_END);
			if ($urandom_range(3) == 0)
				put_random_tlv();
			if ($urandom_range(7) == 0) begin
				cut = $urandom_range(HDR_BYTES, frame_buf.size());
				while (frame_buf.size() > cut)
					void'(frame_buf.pop_back());
			end
		end
		send_frame($urandom_range(11) == 0);
	endtask

	task automatic send_directed();
		// One byte short of the minimum length, so no summary.
		start_frame(LLDP_ETHERTYPE);
		frame_buf.push_back(8'h00);
		send_frame(1'b0);

		// The shortest frame that qualifies: an END TLV right after the ethertype.
		start_frame(LLDP_ETHERTYPE);
		put_tlv(TLV_END);
		send_frame(1'b0);

		// A well-formed TLV list behind a foreign ethertype.
		start_frame(LLDP_ETHERTYPE ^ 16'h0001);
		tlv_val.push_back(CHASSIS_SUB_MAC);
		add_bytes(48'h0123456789ab, 6);
		put_tlv(TLV_CHASSIS);
		put_tlv(TLV_END);
		send_frame(1'b0);

		// Every field at its maximum; the TTL after END must be ignored.
		start_frame(LLDP_ETHERTYPE);
		tlv_val.push_back(CHASSIS_SUB_MAC);
		add_bytes('1, 6);
		put_tlv(TLV_CHASSIS);
		tlv_val.push_back(PORT_SUB_MAC);
		add_bytes('1, 6);
		put_tlv(TLV_PORT);
		add_bytes(48'hffff, 2);
		put_tlv(TLV_TTL);
		add_bytes(48'hffffffff, 4);
		put_tlv(TLV_CAPS);
		tlv_val.push_back(MGMT_ADDR_LEN);
		tlv_val.push_back(ADDR_FAMILY_IPV4);
		add_bytes(48'hffffffff, 4);
		add_bytes(48'h020000000100, 6);
		put_tlv(TLV_MGMT);
		put_tlv(TLV_END);
		add_bytes(48'h0, 2);
		put_tlv(TLV_TTL);
		send_frame(1'b1);

		// IPv4 chassis, named port, zero values, a zero-length TLV, a long vendor TLV,
		// a later TTL that overrides, and a capabilities TLV cut off by the frame end.
		start_frame(LLDP_ETHERTYPE);
		tlv_val.push_back(CHASSIS_SUB_NET);
		tlv_val.push_back(ADDR_FAMILY_IPV4);
		add_bytes(48'h0, 4);
		put_tlv(TLV_CHASSIS);
		tlv_val.push_back(PORT_SUB_IFNAME);
		add_bytes(48'h65746830, 4);
		put_tlv(TLV_PORT);
		add_bytes(48'h0, 2);
		put_tlv(TLV_TTL);
		add_bytes(48'h00140014, 4);
		put_tlv(TLV_CAPS);
		put_tlv(TLV_TTL);
		add_random(260);
		put_tlv(TLV_VENDOR);
		add_bytes(48'h1234, 2);
		put_tlv(TLV_TTL);
		add_bytes(48'h00ff00ff, 4);
		put_tlv(TLV_CAPS);
		void'(frame_buf.pop_back());
		send_frame(1'b0);

		// Forms that fall back to the generic kinds or change nothing.
		start_frame(LLDP_ETHERTYPE);
		tlv_val.push_back(CHASSIS_SUB_LOCAL);
		add_bytes(48'h737731, 3);
		put_tlv(TLV_CHASSIS);
		tlv_val.push_back(CHASSIS_SUB_NET);
		tlv_val.push_back(ADDR_FAMILY_IPV6);
		add_bytes(48'h0a000001, 4);
		put_tlv(TLV_CHASSIS);
		tlv_val.push_back(PORT_SUB_MAC);
		add_bytes(48'h0a0b0c0d0e, 5);
		put_tlv(TLV_PORT);
		tlv_val.push_back(MGMT_LEN_IPV6);
		tlv_val.push_back(ADDR_FAMILY_IPV6);
		add_bytes(48'hfe8000000000, 6);
		put_tlv(TLV_MGMT);
		put_tlv(TLV_END);
		send_frame(1'b0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			frame_in.valid <= 1'b0;
		end else begin
			if (frame_in.valid && frame_in.ready) begin
				parse_byte(byte_stream[0].item);
				void'(byte_stream.pop_front());
				bytes_accepted <= bytes_accepted + 1;
			end
			if (!(frame_in.valid && !frame_in.ready)) begin
				if (byte_stream.size() > 0 && byte_stream[0].hold &&
						expected_summaries.size() == 0)
					byte_stream[0].hold = 1'b0;
				if (byte_stream.size() > 0 && !byte_stream[0].hold &&
						$urandom_range(99) >= sender_idle_pct()) begin
					frame_in.valid <= 1'b1;
					frame_in.data  <= byte_stream[0].item;
				end else begin
					frame_in.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			summary_out.ready <= 1'b0;
		end else begin
			if (summary_out.valid && summary_out.ready)
				check_summary(summary_out.data);
			summary_out.ready <= ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (frame_in.valid && frame_in.ready) ||
				(summary_out.valid && summary_out.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n              = 1'b0;
		frame_in.valid      = 1'b0;
		frame_in.data       = '0;
		summary_out.ready   = 1'b0;
		total_items         = 0;
		bytes_accepted      = 0;
		frames_sent         = 0;
		lldp_frames_planned = 0;
		summaries_checked   = 0;
		mismatches          = 0;
		stall_cycles        = 0;
		clear_frame_state();

		send_directed();
		while (byte_stream.size() < TARGET_BYTES || lldp_frames_planned < TARGET_FRAMES)
			random_frame();
		total_items = byte_stream.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_stream.size() != 0 || expected_summaries.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d frames (%0d bytes) under three idle patterns; checked %0d summaries.",
			frames_sent, total_items, summaries_checked);
		$display("Frames covered short, foreign, truncated and END-terminated TLV lists.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
